FILE: design/min_heap_priority_queue_assert.svh
// Assertion macros for the min-heap priority queue checker.
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MHPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MHPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mhpq_pkg.sv
package mhpq_pkg;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Command word
    typedef struct packed {
        logic        op;
        logic [31:0] value;
    } cmd_word_t;

    // Result word
    typedef struct packed {
        logic [31:0] min_value;
        logic [10:0] entry_count;
        logic        empty_flag;
        logic [1:0]  status;
    } rsp_word_t;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_UP_RD   = 6'b000010,
        S_UP_CMP  = 6'b000100,
        S_DN_LAST = 6'b001000,
        S_DN_RD   = 6'b010000,
        S_DN_CMP  = 6'b100000
    } state_t;

endpackage

FILE: design/min_heap_priority_queue.sv
// Binary min-heap priority queue. Raise start with a command word on cmd while
// busy is low; the command is taken at that edge. A push inserts cmd.value, a
// pop removes the smallest entry; values compare unsigned. Exactly one result
// word per command appears on rsp for a single cycle with done high, and it
// cannot be held off. A push into a full heap or a pop from an empty heap
// leaves the heap untouched, reports its status and returns done on the next
// cycle. Otherwise the entry is sifted through one memory with a registered
// read: each tree level takes a read state and a compare-and-write state. A
// push may climb from the last leaf to the root. A pop first fetches the last
// entry and then descends a heap that is one entry smaller. A new command may
// be issued in the cycle done is high. No clearing pass is needed after reset.
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cmd_word_t cmd,
    output logic      done,
    output rsp_word_t rsp
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int VW = VALUE_WIDTH;

    state_t          state_reg,  state_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic [AW-1:0]   pos_reg,    pos_next;
    logic [VW-1:0]   val_reg,    val_next;
    logic [VW-1:0]   root_reg,   root_next;
    logic [1:0]      status_reg, status_next;
    logic            done_reg,   done_next;

    logic [VW-1:0]   heap_mem [HEAP_DEPTH];
    logic [VW-1:0]   rd_a_data_reg;
    logic [VW-1:0]   rd_b_data_reg;

    logic            rd_en;
    logic [AW-1:0]   rd_a_addr;
    logic [AW-1:0]   rd_b_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [VW-1:0]   wr_data;

    logic [AW-1:0]   parent_idx;
    logic [IW-1:0]   left_idx;
    logic [IW-1:0]   right_idx;
    logic [IW-1:0]   count_ext;
    logic            has_left;
    logic            has_right;
    logic            pick_right;
    logic [VW-1:0]   child_val;
    logic [AW-1:0]   child_idx;
    logic            is_full;

    // Tree navigation from the current hole position
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);
    assign left_idx   = (IW'(pos_reg) << 1) + IW'(1);
    assign right_idx  = left_idx + IW'(1);
    assign count_ext  = IW'(count_reg);
    assign has_left   = left_idx < count_ext;
    assign has_right  = right_idx < count_ext;
    assign pick_right = has_right && (rd_b_data_reg < rd_a_data_reg);
    assign child_val  = pick_right ? rd_b_data_reg : rd_a_data_reg;
    assign child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign is_full    = count_reg == CW'(HEAP_DEPTH);

    // Sequence pushes and pops through the heap memory
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        rd_en       = 1'b0;
        rd_a_addr   = parent_idx;
        rd_b_addr   = right_idx[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (cmd.op == OP_PUSH)
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            pos_next    = count_reg[AW-1:0];
                            val_next    = VW'(cmd.value);
                            count_next  = count_reg + CW'(1);
                            state_next  = S_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // fetch the last entry, which moves to the root
                        status_next = ST_OK;
                        count_next  = count_reg - CW'(1);
                        rd_en       = 1'b1;
                        rd_a_addr   = AW'(count_reg - CW'(1));
                        state_next  = S_DN_LAST;
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_a_data_reg < val_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // move the parent down into the hole
                    wr_data    = rd_a_data_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
            end

            S_DN_LAST:
            begin
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    val_next   = rd_a_data_reg;
                    pos_next   = '0;
                    state_next = S_DN_RD;
                end
            end

            S_DN_RD:
            begin
                if (!has_left)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_a_addr  = left_idx[AW-1:0];
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (val_reg > child_val)
                begin
                    // move the smaller child up into the hole
                    wr_data    = child_val;
                    pos_next   = child_idx;
                    state_next = S_DN_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track the root entry as it is written
    always_comb
    begin
        root_next = root_reg;
        if (wr_en && (wr_addr == '0))
        begin
            root_next = wr_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    // Heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_data_reg <= heap_mem[rd_a_addr];
            rd_b_data_reg <= heap_mem[rd_b_addr];
        end
    end

    // Drive the result word
    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign rsp.min_value   = (count_reg != '0) ? 32'(root_reg) : 32'd0;
    assign rsp.entry_count = 11'(count_reg);
    assign rsp.empty_flag  = count_reg == '0;
    assign rsp.status      = status_reg;

endmodule

FILE: design/mhpq_checker.sv
`include "min_heap_priority_queue_assert.svh"

module mhpq_checker
    import mhpq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input cmd_word_t cmd,
    input logic      done,
    input rsp_word_t rsp
);

    // every completed sift ends with a result word
    `MHPQ_ASSERT_IMP(a_fell_busy_done, $fell(busy), done, "sift ended without a result")

    // results only come out once the queue is free again
    `MHPQ_ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")

    // an empty heap reports a zero minimum
    `MHPQ_ASSERT_IMP(a_empty_min_zero, done && rsp.empty_flag, rsp.min_value == 32'd0,
        "nonzero minimum on an empty heap")

    // a rejected pop leaves the heap empty, a rejected push leaves it nonempty
    `MHPQ_ASSERT_IMP(a_status_flag, done && (rsp.status != ST_OK),
        (rsp.status == ST_EMPTY) == rsp.empty_flag, "status disagrees with empty flag")

    // a pop on an empty heap, issued while done is high, answers on the next cycle
    `MHPQ_ASSERT_NXT(a_empty_pop_fast, start && !busy && (cmd.op == OP_POP) && done &&
        rsp.empty_flag, done && (rsp.status == ST_EMPTY), "empty pop not answered at once")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

FILE: test/testbench.sv
module testbench;
    import mhpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH  = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDLE_LIMIT  = 1000;

    // One row of the directed plan: a command word plus an optional typed answer
    typedef struct {
        logic       op;
        logic [31:0] value;
        bit         typed;
        rsp_word_t  want;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    cmd_word_t cmd;
    logic      done;
    rsp_word_t rsp;

    // Shadow copy of the heap, advanced as each command word is taken
    logic [31:0] heap_mem [HEAP_DEPTH];
    int unsigned heap_len;

    // Result words still owed by the queue, oldest first
    rsp_word_t rsp_due [$];

    plan_row_t plan [$];
    int        errors;
    int        idle_cycles;
    int        burst_left;
    bit        idle_on;

    min_heap_priority_queue #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Apply one command to the shadow heap and return the result word it yields
    function automatic rsp_word_t heap_apply(logic op, logic [31:0] value);
        rsp_word_t   r;
        int unsigned pos;
        int unsigned par;
        int unsigned lc;
        int unsigned pick;
        logic [31:0] tmp;
        bit          settled;
        r.status = ST_OK;
        settled  = 1'b0;
        if (op == OP_PUSH)
        begin
            if (heap_len >= HEAP_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // Append, then sift up while the parent is not strictly smaller
                heap_mem[heap_len] = value;
                pos = heap_len;
                heap_len++;
                while (pos != 0 && !settled)
                begin
                    par = (pos - 1) >> 1;
                    if (heap_mem[par] < heap_mem[pos])
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        tmp = heap_mem[par];
                        heap_mem[par] = heap_mem[pos];
                        heap_mem[pos] = tmp;
                        pos = par;
                    end
                end
            end
        end
        else if (heap_len == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            // Move the last entry to the root, then sift down toward the smaller child
            heap_len--;
            heap_mem[0] = heap_mem[heap_len];
            pos = 0;
            while (!settled)
            begin
                lc = 2 * pos + 1;
                if (lc >= heap_len)
                begin
                    settled = 1'b1;
                end
                else
                begin
                    pick = lc;
                    if (lc + 1 < heap_len && heap_mem[lc + 1] < heap_mem[lc])
                        pick = lc + 1;
                    if (!(heap_mem[pos] > heap_mem[pick]))
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[pick];
                        heap_mem[pick] = tmp;
                        pos = pick;
                    end
                end
            end
        end
        r.min_value   = (heap_len != 0) ? heap_mem[0] : 32'h0;
        r.entry_count = heap_len[10:0];
        r.empty_flag  = (heap_len == 0);
        return r;
    endfunction

    function automatic plan_row_t row(logic op, logic [31:0] value, bit typed,
                                      logic [31:0] min_value, int count,
                                      logic [1:0] status);
        plan_row_t p;
        p.op               = op;
        p.value            = value;
        p.typed            = typed;
        p.want.min_value   = min_value;
        p.want.entry_count = count[10:0];
        p.want.empty_flag  = (count == 0);
        p.want.status      = status;
        return p;
    endfunction

    // Mix full-range values with clusters that force ties and extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Drive one command word, hold it until taken, and log the owed result
    task automatic issue(logic op, logic [31:0] value, bit typed, rsp_word_t want);
        rsp_word_t model;
        if (idle_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 24)) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        start     = 1'b1;
        cmd.op    = op;
        cmd.value = value;
        do
            @(posedge clk);
        while (busy);
        model = heap_apply(op, value);
        rsp_due.push_back(typed ? want : model);
    endtask

    task automatic issue_random(int pop_pct);
        rsp_word_t unused;
        unused = '0;
        issue(($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH,
              $urandom(), 1'b0, unused);
    endtask

    task automatic issue_push(logic [31:0] value);
        rsp_word_t unused;
        unused = '0;
        issue(OP_PUSH, value, 1'b0, unused);
    endtask

    // Drop start and hold off until every owed result word has come back
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
    endtask

    // Check result words and watch for a stall
    always @(posedge clk)
    begin
        rsp_word_t exp_w;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $realtime, rsp);
                    errors++;
                end
                else
                begin
                    exp_w = rsp_due.pop_front();
                    if (rsp.min_value !== exp_w.min_value)
                    begin
                        $display("%0t: min_value expected %h got %h",
                                 $realtime, exp_w.min_value, rsp.min_value);
                        errors++;
                    end
                    if (rsp.entry_count !== exp_w.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d got %0d",
                                 $realtime, exp_w.entry_count, rsp.entry_count);
                        errors++;
                    end
                    if (rsp.empty_flag !== exp_w.empty_flag)
                    begin
                        $display("%0t: empty_flag expected %b got %b",
                                 $realtime, exp_w.empty_flag, rsp.empty_flag);
                        errors++;
                    end
                    if (rsp.status !== exp_w.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $realtime, exp_w.status, rsp.status);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        heap_len    = 0;
        errors      = 0;
        idle_cycles = 0;
        burst_left  = 0;
        idle_on     = 1'b1;

        // Directed plan: empty pop, extremes, ties, pops that ignore value
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'h0000_0000, 0, ST_EMPTY));
        plan.push_back(row(OP_PUSH, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h0000_0000, 1, 32'h0000_0000, 2, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h0000_0000, 1, 32'h0000_0000, 3, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h8000_0000, 1, 32'h0000_0000, 4, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h7FFF_FFFF, 1, 32'h0000_0000, 5, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h0000_0001, 1, 32'h0000_0000, 6, ST_OK));
        plan.push_back(row(OP_PUSH, 32'hFFFF_FFFF, 1, 32'h0000_0000, 7, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'h0000_0000, 6, ST_OK));
        plan.push_back(row(OP_POP,  32'hFFFF_FFFF, 1, 32'h0000_0001, 5, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'h7FFF_FFFF, 4, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'h8000_0000, 3, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'hFFFF_FFFF, 2, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'hFFFF_FFFF, 1, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 1, 32'h0000_0000, 0, ST_OK));
        plan.push_back(row(OP_POP,  32'hFFFF_FFFF, 1, 32'h0000_0000, 0, ST_EMPTY));
        plan.push_back(row(OP_PUSH, 32'h5A5A_5A5A, 1, 32'h5A5A_5A5A, 1, ST_OK));
        plan.push_back(row(OP_PUSH, 32'hA5A5_A5A5, 1, 32'h5A5A_5A5A, 2, ST_OK));
        plan.push_back(row(OP_POP,  32'h1234_5678, 1, 32'hA5A5_A5A5, 1, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h0000_0003, 0, 32'h0, 0, ST_OK));
        plan.push_back(row(OP_PUSH, 32'h0000_0002, 0, 32'h0, 0, ST_OK));
        plan.push_back(row(OP_PUSH, 32'hA5A5_A5A5, 0, 32'h0, 0, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 0, 32'h0, 0, ST_OK));
        plan.push_back(row(OP_POP,  32'h0000_0000, 0, 32'h0, 0, ST_OK));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed plan
        foreach (plan[i])
            issue(plan[i].op, plan[i].value, plan[i].typed, plan[i].want);

        // Churn near empty so pops on empty recur
        repeat (20) issue_random(50);
        drain();

        // Fill to capacity, half of it back to back, then push past full
        while (heap_len < HEAP_DEPTH)
        begin
            idle_on = (heap_len >= HEAP_DEPTH / 2);
            issue_push(pick_value());
        end
        idle_on = 1'b1;
        repeat (3) issue_push(pick_value());
        repeat (10) issue_random(50);
        drain();

        // Pop-heavy run through the deep heap
        repeat (20) issue_random(80);

        drain();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
